FILE: rtl/core/mpx2rgba_pkg.sv
// Shared types, constants and lookup functions for the masked pixel to RGBA8 unpacker.
// No dependencies; every other file in rtl/core refers to this package by scoped names.

package mpx2rgba_pkg;

    // Widths fixed by the pixel and result formats.
    localparam int PIX_W     = 32;
    localparam int OUT_W     = 8;
    localparam int SH_W      = 5;
    localparam int WID_W     = 6;
    localparam int RCP_W     = 31;
    localparam int REM_W     = PIX_W + OUT_W;
    localparam int NCH       = 4;

    // Pipeline layout: stage 0 holds the pixel, stages 1 to 5 find the quotient and
    // remainder of the extracted value, stage ST_REM forms 255 times the remainder,
    // one stage per quotient bit follows, and the last stage is the output register.
    localparam int NSTEP     = OUT_W;
    localparam int ST_REM    = 6;
    localparam int NSTG      = ST_REM + NSTEP + 2;
    localparam int ST_OUT    = NSTG - 1;

    // Cycles needed by the derived channel settings to settle after a register write.
    localparam int DRV_LAT   = 4;
    localparam int DRV_CW    = 3;

    localparam int CFG_IDX_W = 3;
    localparam int BPP_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_MASK   = 3'd0,
        CFG_GREEN_MASK = 3'd1,
        CFG_BLUE_MASK  = 3'd2,
        CFG_ALPHA_MASK = 3'd3,
        CFG_BPP        = 3'd4
    } t_cfg_idx;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    localparam logic [PIX_W-1:0] RST_RED_MASK   = 32'h00FF_0000;
    localparam logic [PIX_W-1:0] RST_GREEN_MASK = 32'h0000_FF00;
    localparam logic [PIX_W-1:0] RST_BLUE_MASK  = 32'h0000_00FF;
    localparam logic [PIX_W-1:0] RST_ALPHA_MASK = 32'hFF00_0000;
    localparam logic [BPP_W-1:0] RST_BPP        = 3'd4;

    localparam logic [OUT_W-1:0] ABSENT_COLOUR  = 8'h00;
    localparam logic [OUT_W-1:0] ABSENT_ALPHA   = 8'hFF;

    // Settings of one channel, derived from its mask and the pixel size.
    typedef struct packed {
        logic [PIX_W-1:0] kmask;   // mask with the unused pixel bytes removed
        logic [SH_W-1:0]  shift;   // lowest set bit of the mask
        logic [WID_W-1:0] width;   // run of ones from the lowest set bit
        logic [RCP_W-1:0] recip;   // floor(2^32 / (2^width - 1)) for widths of two or more
        logic [PIX_W-1:0] div;     // 2^width - 1
        logic             unit;    // width of one, divisor of one
        logic             empty;   // mask is zero
        logic [OUT_W-1:0] absent;  // result for an empty mask
    } t_chan_cfg;

    // Number of trailing zero bits; 32 for an all-zero word.
    function automatic logic [WID_W-1:0] tz_count(input logic [PIX_W-1:0] x);
        logic [PIX_W-1:0] y;
        logic [WID_W-1:0] n;
        y = x;
        n = '0;
        if (y[15:0] == 16'd0) begin
            n = n + 6'd16;
            y = y >> 16;
        end
        if (y[7:0] == 8'd0) begin
            n = n + 6'd8;
            y = y >> 8;
        end
        if (y[3:0] == 4'd0) begin
            n = n + 6'd4;
            y = y >> 4;
        end
        if (y[1:0] == 2'd0) begin
            n = n + 6'd2;
            y = y >> 2;
        end
        if (y[0] == 1'b0) begin
            n = n + 6'd1;
        end
        if (x == '0) begin
            n = 6'd32;
        end
        return n;
    endfunction

    // Reciprocal of the divisor 2^w - 1, scaled by 2^32 and rounded down.
    function automatic logic [RCP_W-1:0] recip_lut(input logic [WID_W-1:0] w);
        logic [RCP_W-1:0] m;
        case (w)
            6'd2:    m = 31'd1431655765;
            6'd3:    m = 31'd613566756;
            6'd4:    m = 31'd286331153;
            6'd5:    m = 31'd138547332;
            6'd6:    m = 31'd68174084;
            6'd7:    m = 31'd33818640;
            6'd8:    m = 31'd16843009;
            6'd9:    m = 31'd8405024;
            6'd10:   m = 31'd4198404;
            6'd11:   m = 31'd2098176;
            6'd12:   m = 31'd1048832;
            6'd13:   m = 31'd524352;
            6'd14:   m = 31'd262160;
            6'd15:   m = 31'd131076;
            6'd16:   m = 31'd65537;
            6'd17:   m = 31'd32768;
            6'd18:   m = 31'd16384;
            6'd19:   m = 31'd8192;
            6'd20:   m = 31'd4096;
            6'd21:   m = 31'd2048;
            6'd22:   m = 31'd1024;
            6'd23:   m = 31'd512;
            6'd24:   m = 31'd256;
            6'd25:   m = 31'd128;
            6'd26:   m = 31'd64;
            6'd27:   m = 31'd32;
            6'd28:   m = 31'd16;
            6'd29:   m = 31'd8;
            6'd30:   m = 31'd4;
            6'd31:   m = 31'd2;
            6'd32:   m = 31'd1;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/mpx2rgba_cfg.sv
// Configuration registers and the derived per-channel settings (shift, width, reciprocal).
// Depends on mpx2rgba_pkg.

module mpx2rgba_cfg (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_cfg_valid,
    input  logic [mpx2rgba_pkg::CFG_IDX_W-1:0]                i_cfg_index,
    input  logic [mpx2rgba_pkg::PIX_W-1:0]                    i_cfg_data,
    output mpx2rgba_pkg::t_chan_cfg [mpx2rgba_pkg::NCH-1:0]   o_chan_cfg,
    output logic                                              o_busy
);

    logic [mpx2rgba_pkg::PIX_W-1:0]  r_mask [mpx2rgba_pkg::NCH];
    logic [mpx2rgba_pkg::BPP_W-1:0]  r_bpp;
    logic [mpx2rgba_pkg::DRV_CW-1:0] r_cnt;
    logic [mpx2rgba_pkg::DRV_CW-1:0] n_cnt;
    logic [mpx2rgba_pkg::PIX_W-1:0]  keep;

    // Derivation pipeline registers.
    logic [mpx2rgba_pkg::PIX_W-1:0]  r_kmask [mpx2rgba_pkg::NCH];
    logic [mpx2rgba_pkg::SH_W-1:0]   r_shift [mpx2rgba_pkg::NCH];
    logic                            r_empty [mpx2rgba_pkg::NCH];
    logic [mpx2rgba_pkg::PIX_W-1:0]  r_run   [mpx2rgba_pkg::NCH];
    logic [mpx2rgba_pkg::WID_W-1:0]  r_width [mpx2rgba_pkg::NCH];
    logic [mpx2rgba_pkg::RCP_W-1:0]  r_recip [mpx2rgba_pkg::NCH];
    logic [mpx2rgba_pkg::PIX_W-1:0]  r_div   [mpx2rgba_pkg::NCH];
    logic                            r_unit  [mpx2rgba_pkg::NCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask[mpx2rgba_pkg::CH_RED]   <= mpx2rgba_pkg::RST_RED_MASK;
            r_mask[mpx2rgba_pkg::CH_GREEN] <= mpx2rgba_pkg::RST_GREEN_MASK;
            r_mask[mpx2rgba_pkg::CH_BLUE]  <= mpx2rgba_pkg::RST_BLUE_MASK;
            r_mask[mpx2rgba_pkg::CH_ALPHA] <= mpx2rgba_pkg::RST_ALPHA_MASK;
            r_bpp                          <= mpx2rgba_pkg::RST_BPP;
        end else if (i_cfg_valid) begin
            case (mpx2rgba_pkg::t_cfg_idx'(i_cfg_index))
                mpx2rgba_pkg::CFG_RED_MASK:   r_mask[mpx2rgba_pkg::CH_RED]   <= i_cfg_data;
                mpx2rgba_pkg::CFG_GREEN_MASK: r_mask[mpx2rgba_pkg::CH_GREEN] <= i_cfg_data;
                mpx2rgba_pkg::CFG_BLUE_MASK:  r_mask[mpx2rgba_pkg::CH_BLUE]  <= i_cfg_data;
                mpx2rgba_pkg::CFG_ALPHA_MASK: r_mask[mpx2rgba_pkg::CH_ALPHA] <= i_cfg_data;
                mpx2rgba_pkg::CFG_BPP:        r_bpp <= i_cfg_data[mpx2rgba_pkg::BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // The derived settings trail the registers through the derivation pipeline, so hold off pixels.
    always_comb begin
        if (i_cfg_valid) begin
            n_cnt = (mpx2rgba_pkg::DRV_CW)'(mpx2rgba_pkg::DRV_LAT);
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - (mpx2rgba_pkg::DRV_CW)'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= (mpx2rgba_pkg::DRV_CW)'(mpx2rgba_pkg::DRV_LAT);
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_busy = (r_cnt != '0);

    always_comb begin
        case (r_bpp)
            3'd0:    keep = 32'h0000_0000;
            3'd1:    keep = 32'h0000_00FF;
            3'd2:    keep = 32'h0000_FFFF;
            3'd3:    keep = 32'h00FF_FFFF;
            default: keep = 32'hFFFF_FFFF;
        endcase
    end

    for (genvar c = 0; c < mpx2rgba_pkg::NCH; c++) begin : g_ch
        logic [mpx2rgba_pkg::WID_W-1:0] tz;
        logic [mpx2rgba_pkg::PIX_W:0]   div_full;

        assign tz       = mpx2rgba_pkg::tz_count(r_mask[c]);
        assign div_full = ((mpx2rgba_pkg::PIX_W+1)'(1) << r_width[c])
                          - (mpx2rgba_pkg::PIX_W+1)'(1);

        always_ff @(posedge i_clk) begin
            r_kmask[c] <= r_mask[c] & keep;
            r_shift[c] <= tz[mpx2rgba_pkg::SH_W-1:0];
            r_empty[c] <= (r_mask[c] == '0);
            r_run[c]   <= r_mask[c] >> r_shift[c];
            r_width[c] <= mpx2rgba_pkg::tz_count(~r_run[c]);
            r_recip[c] <= mpx2rgba_pkg::recip_lut(r_width[c]);
            r_div[c]   <= div_full[mpx2rgba_pkg::PIX_W-1:0];
            r_unit[c]  <= (r_width[c] == 6'd1);
        end

        assign o_chan_cfg[c].kmask  = r_kmask[c];
        assign o_chan_cfg[c].shift  = r_shift[c];
        assign o_chan_cfg[c].width  = r_width[c];
        assign o_chan_cfg[c].recip  = r_recip[c];
        assign o_chan_cfg[c].div    = r_div[c];
        assign o_chan_cfg[c].unit   = r_unit[c];
        assign o_chan_cfg[c].empty  = r_empty[c];
        assign o_chan_cfg[c].absent = (c == mpx2rgba_pkg::CH_ALPHA) ?
                                      mpx2rgba_pkg::ABSENT_ALPHA :
                                      mpx2rgba_pkg::ABSENT_COLOUR;
    end

endmodule

FILE: rtl/core/mpx2rgba_ctrl.sv
// Valid tracking and per-stage load enables of the pixel pipeline, with back pressure.
// Depends on mpx2rgba_pkg.

module mpx2rgba_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_out_ready,
    input  logic                            i_busy,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    output logic [mpx2rgba_pkg::NSTG-1:0]   o_load
);

    logic [mpx2rgba_pkg::NSTG-1:0] r_vld;
    logic [mpx2rgba_pkg::NSTG-1:0] n_vld;
    logic [mpx2rgba_pkg::NSTG-1:0] vld_n;
    logic                          in_fire;

    assign vld_n = ~r_vld;

    // A stage may load when it or any later stage holds a bubble, or the output drains.
    always_comb begin
        for (int k = 0; k < mpx2rgba_pkg::NSTG; k++) begin
            o_load[k] = i_out_ready | (|(vld_n >> k));
        end
    end

    assign o_in_ready = o_load[0] & ~i_busy;
    assign in_fire    = i_in_valid & o_in_ready;

    always_comb begin
        n_vld[0] = o_load[0] ? in_fire : r_vld[0];
        for (int k = 1; k < mpx2rgba_pkg::NSTG; k++) begin
            n_vld[k] = o_load[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_out_valid = r_vld[mpx2rgba_pkg::ST_OUT];

endmodule

FILE: rtl/core/mpx2rgba_chan.sv
// Datapath of one colour channel: extract, divide by 2^width - 1 and scale to eight bits.
// Depends on mpx2rgba_pkg; stage load enables come from mpx2rgba_ctrl.

module mpx2rgba_chan (
    input  logic                                i_clk,
    input  logic [mpx2rgba_pkg::NSTG-1:0]       i_load,
    input  mpx2rgba_pkg::t_chan_cfg             i_cfg,
    input  logic [mpx2rgba_pkg::PIX_W-1:0]      i_pix,
    output logic [mpx2rgba_pkg::OUT_W-1:0]      o_value
);

    localparam int PW  = mpx2rgba_pkg::PIX_W;
    localparam int OW  = mpx2rgba_pkg::OUT_W;
    localparam int RW  = mpx2rgba_pkg::REM_W;
    localparam int MW  = mpx2rgba_pkg::RCP_W;
    localparam int PRW = PW + MW;
    localparam int NS  = mpx2rgba_pkg::NSTEP;
    localparam int SR  = mpx2rgba_pkg::ST_REM;

    // Stage 1: masked field moved down to bit zero.
    logic [PW-1:0]  r_v1;
    // Stage 2: value times the scaled reciprocal.
    logic [PRW-1:0] r_prod;
    logic [PW-1:0]  r_v2;
    // Stage 3: estimated quotient times the divisor.
    logic [PW-1:0]  r_qd;
    logic [OW-1:0]  r_q3;
    logic [OW-1:0]  r_v3;
    // The full value is needed one stage later than the product, so it moves with r_qd.
    logic [PW-1:0]  r_v2_hold;
    // Stage 4: estimated remainder, below twice the divisor.
    logic [PW:0]    r_rve;
    logic [OW-1:0]  r_q4;
    logic [OW-1:0]  r_v4;
    // Stage 5: exact remainder and low bits of the exact quotient.
    logic [PW-1:0]  r_rv;
    logic [OW-1:0]  r_qv5;
    // Stages SR to SR + NS: restoring division of 255 times the remainder.
    logic [RW-1:0]  r_rem [NS+1];
    logic [OW-1:0]  r_t   [NS+1];
    logic [OW-1:0]  r_qv  [NS+1];
    // Output stage.
    logic [OW-1:0]  r_out;

    logic [PRW-1:0] n_prod;
    logic [PW-1:0]  qe;
    logic [PW:0]    n_qd;
    logic [PW+1:0]  diff;
    logic           ge;

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_v1 <= (i_pix & i_cfg.kmask) >> i_cfg.shift;
        end
    end

    assign n_prod = {{MW{1'b0}}, r_v1} * {{PW{1'b0}}, i_cfg.recip};

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_prod <= n_prod;
            r_v2   <= r_v1;
        end
    end

    // The product of quotient and divisor never exceeds the value, so 33 bits hold it.
    assign qe   = {1'b0, r_prod[PRW-1:PW]};
    assign n_qd = ({1'b0, qe} << i_cfg.width) - {1'b0, qe};

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r_qd <= n_qd[PW-1:0];
            r_q3 <= qe[OW-1:0];
            r_v3 <= r_v2[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r_rve <= {1'b0, r_v2_hold} - {1'b0, r_qd};
            r_q4  <= r_q3;
            r_v4  <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r_v2_hold <= r_v2;
        end
    end

    assign diff = {1'b0, r_rve} - {2'b00, i_cfg.div};
    assign ge   = ~diff[PW+1];

    always_ff @(posedge i_clk) begin
        if (i_load[5]) begin
            if (i_cfg.unit) begin
                r_rv  <= '0;
                r_qv5 <= r_v4;
            end else begin
                r_rv  <= ge ? diff[PW-1:0] : r_rve[PW-1:0];
                r_qv5 <= r_q4 + OW'(ge);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[SR]) begin
            r_rem[0] <= {r_rv, {OW{1'b0}}} - {{OW{1'b0}}, r_rv};
            r_t[0]   <= '0;
            r_qv[0]  <= r_qv5;
        end
    end

    // One quotient bit per stage, most significant first; the quotient stays below 256.
    for (genvar j = 0; j < NS; j++) begin : g_step
        localparam int SH = NS - 1 - j;
        logic [RW-1:0] dsh;
        logic          take;

        assign dsh  = {{OW{1'b0}}, i_cfg.div} << SH;
        assign take = (r_rem[j] >= dsh);

        always_ff @(posedge i_clk) begin
            if (i_load[SR+1+j]) begin
                r_rem[j+1] <= take ? (r_rem[j] - dsh) : r_rem[j];
                r_t[j+1]   <= take ? (r_t[j] | (OW'(1) << SH)) : r_t[j];
                r_qv[j+1]  <= r_qv[j];
            end
        end
    end

    // Scaled quotient is 255 * qv + t; modulo 256 that is t - qv.
    always_ff @(posedge i_clk) begin
        if (i_load[mpx2rgba_pkg::ST_OUT]) begin
            r_out <= i_cfg.empty ? i_cfg.absent : (r_t[NS] - r_qv[NS]);
        end
    end

    assign o_value = r_out;

endmodule

FILE: rtl/core/masked_pixel_to_rgba8_top.sv
// Top level of the masked pixel to RGBA8 unpacker: configuration, control and four channels.
// Depends on mpx2rgba_pkg, mpx2rgba_cfg, mpx2rgba_ctrl and mpx2rgba_chan.
//
// Usage
// The block turns one packed pixel of one, two, three or four little-endian bytes into
// 8-bit red, green, blue and alpha, each channel placed by a bit mask register.
// Pixels arrive on the i_pix_valid / o_pix_ready channel with the word on
// i_pixel_word; results leave on o_rgba_valid / i_rgba_ready. A transaction
// completes at a rising edge where valid and ready are both high.
// Registers are written through i_cfg_valid / o_cfg_ready with i_cfg_index and
// i_cfg_data; index 0 to 3 are the red, green, blue and alpha masks, 4 is the
// pixel size in bytes. o_cfg_ready is always high. Writes belong in idle periods.
// Each pixel passes through the 16-stage pipeline (field extraction, a reciprocal
// multiply, a remainder correction and one stage for each of the eight
// restoring-division steps).
// Throughput: one pixel per cycle while i_rgba_ready is high and no register write is settling.
// Reset (synchronous, active low) restores the default masks for 32-bit BGRA
// and empties the pipeline. After reset and after every register write the
// derived channel settings settle in their own registers and o_pix_ready stays
// low until they do. When the receiver stalls, results stay in the pipeline and new
// pixels are taken until every stage is full; nothing is dropped or repeated.

module masked_pixel_to_rgba8_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_pix_valid,
    output logic                                    o_pix_ready,
    input  logic [mpx2rgba_pkg::PIX_W-1:0]          i_pixel_word,
    output logic                                    o_rgba_valid,
    input  logic                                    i_rgba_ready,
    output logic [mpx2rgba_pkg::OUT_W-1:0]          o_red_out,
    output logic [mpx2rgba_pkg::OUT_W-1:0]          o_green_out,
    output logic [mpx2rgba_pkg::OUT_W-1:0]          o_blue_out,
    output logic [mpx2rgba_pkg::OUT_W-1:0]          o_alpha_out,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [mpx2rgba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mpx2rgba_pkg::PIX_W-1:0]          i_cfg_data
);

    mpx2rgba_pkg::t_chan_cfg [mpx2rgba_pkg::NCH-1:0] chan_cfg;
    logic                                            busy;
    logic [mpx2rgba_pkg::NSTG-1:0]                   load;
    logic [mpx2rgba_pkg::PIX_W-1:0]                  r_pix;
    logic [mpx2rgba_pkg::OUT_W-1:0]                  value [mpx2rgba_pkg::NCH];

    // Register writes are never refused; the pixel side waits for the settings instead.
    assign o_cfg_ready = 1'b1;

    mpx2rgba_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_chan_cfg  (chan_cfg),
        .o_busy      (busy)
    );

    mpx2rgba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix_valid),
        .i_out_ready (i_rgba_ready),
        .i_busy      (busy),
        .o_in_ready  (o_pix_ready),
        .o_out_valid (o_rgba_valid),
        .o_load      (load)
    );

    // Stage 0 captures the accepted pixel; all four channels read it.
    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r_pix <= i_pixel_word;
        end
    end

    for (genvar c = 0; c < mpx2rgba_pkg::NCH; c++) begin : g_chan
        mpx2rgba_chan u_chan (
            .i_clk   (i_clk),
            .i_load  (load),
            .i_cfg   (chan_cfg[c]),
            .i_pix   (r_pix),
            .o_value (value[c])
        );
    end

    assign o_red_out   = value[mpx2rgba_pkg::CH_RED];
    assign o_green_out = value[mpx2rgba_pkg::CH_GREEN];
    assign o_blue_out  = value[mpx2rgba_pkg::CH_BLUE];
    assign o_alpha_out = value[mpx2rgba_pkg::CH_ALPHA];

endmodule
